### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond holds in the same cycle as trig.
`define ASSERT_IMPLY(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Check that cond holds in the cycle after trig.
`define ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

### rtl/tlfrq_pkg.sv
package tlfrq_pkg;

    localparam int MAX_THREADS_DEF = 32;
    localparam int BURST_BITS_DEF  = 16;

    // request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_PICK   = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    // level codes
    localparam logic [1:0] LVL_SRT = 2'd0;
    localparam logic [1:0] LVL_ID  = 2'd1;
    localparam logic [1:0] LVL_RR  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_UPPER_FLOOR  = 3'd0;
    localparam logic [2:0] CFG_MIDDLE_FLOOR = 3'd1;
    localparam logic [2:0] CFG_WAIT_INC     = 3'd2;
    localparam logic [2:0] CFG_WAIT_LIMIT   = 3'd3;
    localparam logic [2:0] CFG_PRIO_BOOST   = 3'd4;
    localparam logic [2:0] CFG_PRIO_CEIL    = 3'd5;

    localparam logic [7:0] UPPER_FLOOR_RST  = 8'd100;
    localparam logic [7:0] MIDDLE_FLOOR_RST = 8'd50;
    localparam logic [7:0] WAIT_INC_RST     = 8'd100;
    localparam logic [8:0] WAIT_LIMIT_RST   = 9'd400;
    localparam logic [4:0] PRIO_BOOST_RST   = 5'd10;
    localparam logic [7:0] PRIO_CEIL_RST    = 8'd149;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PICK_SCAN,
        ST_PICK_DONE,
        ST_AGE_SCAN,
        ST_RP_SCAN,
        ST_RP_PLACE
    } state_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  thread_id;
        logic [7:0]  thread_priority;
        logic [15:0] thread_remaining;
        logic [7:0]  running_id;
        logic [7:0]  running_priority;
        logic [15:0] running_remaining;
    } req_t;

    typedef struct packed {
        logic       next_valid;
        logic [7:0] next_id;
        logic [1:0] next_level;
        logic       preempt;
        logic       insert_dropped;
    } result_t;

endpackage

### rtl/tlfrq_mem.sv
module tlfrq_mem #(
    parameter int DEPTH = tlfrq_pkg::MAX_THREADS_DEF,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(tlfrq_pkg::MAX_THREADS_DEF)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/three_level_feedback_ready_queue.sv
// Three-level ready queue with aging. An insert completes in the cycle it is
// taken and its result strobes on the next cycle; busy stays low. A pick
// scans the entry memory one entry per cycle and then strobes its result.
// An aging tick takes one scan to age every valid entry, then one full scan
// of the single read port per re-placed entry, plus one per source level that
// finds it drained, to find the next entry in queue order; the strobe follows
// in the cycle after the final placement state. Results appear on result for
// exactly one cycle with result_valid high; the receiver cannot stall, so
// capture them then. Configuration writes are taken at any cycle but belong
// to idle periods.

`include "assert_macros.svh"

module three_level_feedback_ready_queue #(
    parameter int MAX_THREADS = tlfrq_pkg::MAX_THREADS_DEF,
    parameter int BURST_BITS  = tlfrq_pkg::BURST_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  tlfrq_pkg::req_t    req,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [8:0]         cfg_data,
    output logic               result_valid,
    output tlfrq_pkg::result_t result
);

    localparam int IDX_W = $clog2(MAX_THREADS);
    localparam int CNT_W = $clog2(MAX_THREADS + 1);

    typedef struct packed {
        logic [7:0]            id;
        logic [7:0]            prio;
        logic [BURST_BITS-1:0] rem;
        logic [9:0]            wtime;
        logic [1:0]            level;
        logic [15:0]           arrival;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Configuration
    logic [7:0] upper_floor_reg, middle_floor_reg, wait_inc_reg, prio_ceil_reg;
    logic [8:0] wait_limit_reg;
    logic [4:0] prio_boost_reg;

    // Control
    tlfrq_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0]       pipe_idx_reg, pipe_idx_next;
    logic [MAX_THREADS-1:0] valid_reg, valid_next;
    logic [1:0]             due_reg [MAX_THREADS];
    logic [1:0]             due_next [MAX_THREADS];
    logic [15:0]            arrival_reg, arrival_next;
    logic                   src_reg, src_next;
    logic                   preempt_reg, preempt_next;
    logic [2:0]             best_vld_reg, best_vld_next;
    logic [IDX_W-1:0]       best_idx_reg [3];
    logic [IDX_W-1:0]       best_idx_next [3];
    tlfrq_pkg::result_t     res_reg, res_next;
    logic                   res_valid_reg, res_valid_next;

    // Payload
    entry_t                 best_ent_reg [3];
    entry_t                 best_ent_next [3];
    tlfrq_pkg::req_t        job_reg, job_next;

    // Entry memory
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr, mem_raddr;
    entry_t                 mem_wdata;
    logic [ENTRY_W-1:0]     mem_rdata;
    entry_t                 cand;

    tlfrq_mem #(
        .DEPTH (MAX_THREADS),
        .WIDTH (ENTRY_W),
        .AW    (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cand = entry_t'(mem_rdata);

    // Strict queue order: true when c goes ahead of b. Scan runs by
    // ascending index, so a tie keeps the held (lower index) entry.
    function automatic logic better(input logic [1:0] lvl, input entry_t c,
                                    input entry_t b, input logic [15:0] ctr);
        logic [15:0] age_c;
        logic [15:0] age_b;
        logic        older;
        age_c = ctr - c.arrival;
        age_b = ctr - b.arrival;
        older = age_c > age_b;
        case (lvl)
            tlfrq_pkg::LVL_SRT:
            begin
                if (c.rem != b.rem)
                    return c.rem < b.rem;
                if (c.prio != b.prio)
                    return c.prio > b.prio;
                return older;
            end
            tlfrq_pkg::LVL_ID:
            begin
                if (c.id != b.id)
                    return c.id < b.id;
                return older;
            end
            default: return older;
        endcase
    endfunction

    function automatic logic [1:0] level_of(input logic [7:0] prio,
                                            input logic [7:0] upper,
                                            input logic [7:0] middle);
        if (prio >= upper)
            return tlfrq_pkg::LVL_SRT;
        if (prio >= middle)
            return tlfrq_pkg::LVL_ID;
        return tlfrq_pkg::LVL_RR;
    endfunction

    // Preempt test for a placement into level one
    function automatic logic wants_cpu(input logic [1:0] lvl, input entry_t e,
                                       input tlfrq_pkg::req_t r);
        return (lvl == tlfrq_pkg::LVL_SRT) && (r.running_id != 8'd0) &&
               ((e.rem < BURST_BITS'(r.running_remaining)) ||
                (e.prio > r.running_priority));
    endfunction

    always_comb
    begin
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
        entry_t           ins;
        entry_t           upd;
        logic [1:0]       lvl;
        logic [10:0]      w;
        logic [8:0]       p;
        logic [1:0]       want;
        logic             scan_end;

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pipe_vld_next  = 1'b0;
        pipe_idx_next  = pipe_idx_reg;
        valid_next     = valid_reg;
        due_next       = due_reg;
        arrival_next   = arrival_reg;
        src_next       = src_reg;
        preempt_next   = preempt_reg;
        best_vld_next  = best_vld_reg;
        best_idx_next  = best_idx_reg;
        best_ent_next  = best_ent_reg;
        job_next       = job_reg;
        res_next       = '0;
        res_valid_next = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = pipe_idx_reg;
        mem_wdata      = cand;
        mem_raddr      = cnt_reg[IDX_W-1:0];
        ins            = '0;
        upd            = cand;
        lvl            = tlfrq_pkg::LVL_SRT;
        w              = '0;
        p              = '0;
        want           = src_reg ? tlfrq_pkg::LVL_RR : tlfrq_pkg::LVL_ID;
        scan_end       = cnt_reg == CNT_W'(MAX_THREADS);

        // Lowest free slot
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = MAX_THREADS - 1; k >= 0; k--)
        begin
            if (!valid_reg[k])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(k);
            end
        end

        // Shared scan address sequencer: issue one read per cycle
        if ((state_reg == tlfrq_pkg::ST_PICK_SCAN ||
             state_reg == tlfrq_pkg::ST_AGE_SCAN ||
             state_reg == tlfrq_pkg::ST_RP_SCAN) && !scan_end)
        begin
            pipe_vld_next = 1'b1;
            pipe_idx_next = cnt_reg[IDX_W-1:0];
            cnt_next      = cnt_reg + 1'b1;
        end

        case (state_reg)
            tlfrq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    job_next      = req;
                    cnt_next      = '0;
                    best_vld_next = '0;
                    preempt_next  = 1'b0;
                    case (req.req_type)
                        tlfrq_pkg::REQ_INSERT:
                        begin
                            res_valid_next = 1'b1;
                            if (free_found)
                            begin
                                lvl         = level_of(req.thread_priority,
                                                       upper_floor_reg,
                                                       middle_floor_reg);
                                ins.id      = req.thread_id;
                                ins.prio    = req.thread_priority;
                                ins.rem     = BURST_BITS'(req.thread_remaining);
                                ins.wtime   = '0;
                                ins.level   = lvl;
                                ins.arrival = arrival_reg;
                                mem_we      = 1'b1;
                                mem_waddr   = free_idx;
                                mem_wdata   = ins;
                                valid_next[free_idx] = 1'b1;
                                arrival_next = arrival_reg + 16'd1;
                                res_next.preempt = wants_cpu(lvl, ins, req);
                            end
                            else
                            begin
                                res_next.insert_dropped = 1'b1;
                            end
                        end
                        tlfrq_pkg::REQ_PICK: state_next = tlfrq_pkg::ST_PICK_SCAN;
                        tlfrq_pkg::REQ_TICK: state_next = tlfrq_pkg::ST_AGE_SCAN;
                        default:             res_valid_next = 1'b1;
                    endcase
                end
            end

            tlfrq_pkg::ST_PICK_SCAN:
            begin
                // Track the head of each level at once
                if (pipe_vld_reg && valid_reg[pipe_idx_reg])
                begin
                    for (int l = 0; l < 3; l++)
                    begin
                        if (cand.level == 2'(l) &&
                            (!best_vld_reg[l] ||
                             better(2'(l), cand, best_ent_reg[l], arrival_reg)))
                        begin
                            best_vld_next[l] = 1'b1;
                            best_idx_next[l] = pipe_idx_reg;
                            best_ent_next[l] = cand;
                        end
                    end
                end
                if (scan_end)
                    state_next = tlfrq_pkg::ST_PICK_DONE;
            end

            tlfrq_pkg::ST_PICK_DONE:
            begin
                // Drop the head of the highest non-empty level
                res_valid_next = 1'b1;
                state_next     = tlfrq_pkg::ST_IDLE;
                if (best_vld_reg[0])
                begin
                    valid_next[best_idx_reg[0]] = 1'b0;
                    res_next.next_valid = 1'b1;
                    res_next.next_id    = best_ent_reg[0].id;
                    res_next.next_level = tlfrq_pkg::LVL_SRT;
                end
                else if (best_vld_reg[1])
                begin
                    valid_next[best_idx_reg[1]] = 1'b0;
                    res_next.next_valid = 1'b1;
                    res_next.next_id    = best_ent_reg[1].id;
                    res_next.next_level = tlfrq_pkg::LVL_ID;
                end
                else if (best_vld_reg[2])
                begin
                    valid_next[best_idx_reg[2]] = 1'b0;
                    res_next.next_valid = 1'b1;
                    res_next.next_id    = best_ent_reg[2].id;
                    res_next.next_level = tlfrq_pkg::LVL_RR;
                end
            end

            tlfrq_pkg::ST_AGE_SCAN:
            begin
                // Read-modify-write one entry per cycle; the write trails the
                // read by one entry, so no two accesses hit the same entry.
                if (pipe_vld_reg && valid_reg[pipe_idx_reg])
                begin
                    w = {1'b0, cand.wtime} + 11'(wait_inc_reg);
                    if (w > 11'(wait_limit_reg))
                    begin
                        p = 9'(cand.prio) + 9'(prio_boost_reg);
                        if (cand.level == tlfrq_pkg::LVL_SRT)
                        begin
                            if (p > 9'(prio_ceil_reg))
                                p = 9'(prio_ceil_reg);
                        end
                        else
                        begin
                            if (p[8])
                                p = 9'd255;
                            due_next[pipe_idx_reg] = cand.level;
                        end
                        upd.prio = p[7:0];
                        w = w - 11'(wait_limit_reg);
                    end
                    upd.wtime = w[9:0];
                    mem_we    = 1'b1;
                    mem_waddr = pipe_idx_reg;
                    mem_wdata = upd;
                end
                if (scan_end)
                begin
                    state_next    = tlfrq_pkg::ST_RP_SCAN;
                    cnt_next      = '0;
                    src_next      = 1'b0;
                    best_vld_next = '0;
                end
            end

            tlfrq_pkg::ST_RP_SCAN:
            begin
                // Find the next due entry of the current source level
                if (pipe_vld_reg && due_reg[pipe_idx_reg] == want &&
                    (!best_vld_reg[0] ||
                     better(want, cand, best_ent_reg[0], arrival_reg)))
                begin
                    best_vld_next[0] = 1'b1;
                    best_idx_next[0] = pipe_idx_reg;
                    best_ent_next[0] = cand;
                end
                if (scan_end)
                    state_next = tlfrq_pkg::ST_RP_PLACE;
            end

            tlfrq_pkg::ST_RP_PLACE:
            begin
                cnt_next      = '0;
                best_vld_next = '0;
                if (best_vld_reg[0])
                begin
                    upd         = best_ent_reg[0];
                    lvl         = level_of(upd.prio, upper_floor_reg, middle_floor_reg);
                    upd.level   = lvl;
                    upd.arrival = arrival_reg;
                    mem_we      = 1'b1;
                    mem_waddr   = best_idx_reg[0];
                    mem_wdata   = upd;
                    due_next[best_idx_reg[0]] = 2'd0;
                    arrival_next = arrival_reg + 16'd1;
                    preempt_next = preempt_reg | wants_cpu(lvl, upd, job_reg);
                    state_next   = tlfrq_pkg::ST_RP_SCAN;
                end
                else if (!src_reg)
                begin
                    // level two drained; advance to level three
                    src_next   = 1'b1;
                    state_next = tlfrq_pkg::ST_RP_SCAN;
                end
                else
                begin
                    res_valid_next   = 1'b1;
                    res_next.preempt = preempt_reg;
                    state_next       = tlfrq_pkg::ST_IDLE;
                end
            end

            default: state_next = tlfrq_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlfrq_pkg::ST_IDLE;
            cnt_reg       <= '0;
            pipe_vld_reg  <= 1'b0;
            pipe_idx_reg  <= '0;
            valid_reg     <= '0;
            for (int k = 0; k < MAX_THREADS; k++)
                due_reg[k] <= 2'd0;
            arrival_reg   <= '0;
            src_reg       <= 1'b0;
            preempt_reg   <= 1'b0;
            best_vld_reg  <= '0;
            for (int l = 0; l < 3; l++)
                best_idx_reg[l] <= '0;
            res_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pipe_vld_reg  <= pipe_vld_next;
            pipe_idx_reg  <= pipe_idx_next;
            valid_reg     <= valid_next;
            due_reg       <= due_next;
            arrival_reg   <= arrival_next;
            src_reg       <= src_next;
            preempt_reg   <= preempt_next;
            best_vld_reg  <= best_vld_next;
            best_idx_reg  <= best_idx_next;
            res_reg       <= res_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_ent_reg <= best_ent_next;
        job_reg      <= job_next;
    end

    // Configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_floor_reg  <= tlfrq_pkg::UPPER_FLOOR_RST;
            middle_floor_reg <= tlfrq_pkg::MIDDLE_FLOOR_RST;
            wait_inc_reg     <= tlfrq_pkg::WAIT_INC_RST;
            wait_limit_reg   <= tlfrq_pkg::WAIT_LIMIT_RST;
            prio_boost_reg   <= tlfrq_pkg::PRIO_BOOST_RST;
            prio_ceil_reg    <= tlfrq_pkg::PRIO_CEIL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tlfrq_pkg::CFG_UPPER_FLOOR:  upper_floor_reg  <= cfg_data[7:0];
                tlfrq_pkg::CFG_MIDDLE_FLOOR: middle_floor_reg <= cfg_data[7:0];
                tlfrq_pkg::CFG_WAIT_INC:     wait_inc_reg     <= cfg_data[7:0];
                tlfrq_pkg::CFG_WAIT_LIMIT:   wait_limit_reg   <= cfg_data;
                tlfrq_pkg::CFG_PRIO_BOOST:   prio_boost_reg   <= cfg_data[4:0];
                tlfrq_pkg::CFG_PRIO_CEIL:    prio_ceil_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign busy         = state_reg != tlfrq_pkg::ST_IDLE;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // A transfer never reports both a pick and a dropped insert
    `ASSERT_IMPLY(a_res_excl, clk, rst_n, result_valid,
        !(result.next_valid && result.insert_dropped), "pick and drop in one result")

    // Scanning requests hold the block busy
    `ASSERT_NEXT(a_scan_busy, clk, rst_n,
        start && !busy && (req.req_type == tlfrq_pkg::REQ_PICK ||
                           req.req_type == tlfrq_pkg::REQ_TICK),
        busy && !result_valid, "scan request did not hold busy")

    // An insert into a full table is dropped
    `ASSERT_NEXT(a_full_drop, clk, rst_n,
        start && !busy && req.req_type == tlfrq_pkg::REQ_INSERT && (&valid_reg),
        result_valid && result.insert_dropped, "insert into full table not dropped")

endmodule

### verif/three_level_feedback_ready_queue_tb.sv
module three_level_feedback_ready_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = tlfrq_pkg::MAX_THREADS_DEF;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    tlfrq_pkg::req_t    req;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [8:0]         cfg_data;
    logic               result_valid;
    tlfrq_pkg::result_t result;

    three_level_feedback_ready_queue dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .result_valid(result_valid),
        .result(result)
    );

    // Shadow copy of the scheduler table and registers.
    logic        sh_valid [NSLOT];
    logic [7:0]  sh_id [NSLOT];
    logic [7:0]  sh_prio [NSLOT];
    logic [15:0] sh_rem [NSLOT];
    logic [9:0]  sh_wait [NSLOT];
    logic [1:0]  sh_lvl [NSLOT];
    logic [15:0] sh_arr [NSLOT];
    logic [15:0] sh_arr_ctr;

    logic [7:0] r_upper, r_middle, r_winc, r_ceil;
    logic [8:0] r_wlim;
    logic [4:0] r_boost;

    tlfrq_pkg::req_t    pending_reqs [$];
    tlfrq_pkg::result_t expected_results [$];
    int                 mismatches;

    logic               busy_at_edge;
    logic               hold_off;
    int                 gap_left;
    tlfrq_pkg::result_t want;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Older entry wins; ties go to the lower slot.
    function automatic bit older(int a, int b);
        logic [15:0] ga, gb;
        ga = sh_arr_ctr - sh_arr[a];
        gb = sh_arr_ctr - sh_arr[b];
        if (ga != gb) return ga > gb;
        return a < b;
    endfunction

    function automatic bit ahead_of(logic [1:0] lvl, int a, int b);
        if (lvl == tlfrq_pkg::LVL_SRT)
        begin
            if (sh_rem[a] != sh_rem[b]) return sh_rem[a] < sh_rem[b];
            if (sh_prio[a] != sh_prio[b]) return sh_prio[a] > sh_prio[b];
            return older(a, b);
        end
        if (lvl == tlfrq_pkg::LVL_ID)
        begin
            if (sh_id[a] != sh_id[b]) return sh_id[a] < sh_id[b];
            return older(a, b);
        end
        return older(a, b);
    endfunction

    // Assign level and arrival; return whether the running thread is preempted.
    function automatic bit place_entry(int i, tlfrq_pkg::req_t r);
        logic [1:0] lvl;
        if (sh_prio[i] >= r_upper) lvl = tlfrq_pkg::LVL_SRT;
        else if (sh_prio[i] >= r_middle) lvl = tlfrq_pkg::LVL_ID;
        else lvl = tlfrq_pkg::LVL_RR;
        sh_lvl[i] = lvl;
        sh_arr[i] = sh_arr_ctr;
        sh_arr_ctr = sh_arr_ctr + 16'd1;
        if (lvl != tlfrq_pkg::LVL_SRT) return 1'b0;
        return r.running_id != 8'd0 &&
               (sh_rem[i] < r.running_remaining || sh_prio[i] > r.running_priority);
    endfunction

    function automatic tlfrq_pkg::result_t schedule_step(tlfrq_pkg::req_t r);
        tlfrq_pkg::result_t res;
        int slot, best;
        logic [1:0] due [NSLOT];
        int w, p;
        res = '0;
        if (r.req_type == tlfrq_pkg::REQ_INSERT)
        begin
            slot = -1;
            for (int i = 0; i < NSLOT; i++)
                if (!sh_valid[i] && slot < 0) slot = i;
            if (slot < 0) res.insert_dropped = 1'b1;
            else
            begin
                sh_valid[slot] = 1'b1;
                sh_id[slot] = r.thread_id;
                sh_prio[slot] = r.thread_priority;
                sh_rem[slot] = r.thread_remaining;
                sh_wait[slot] = '0;
                res.preempt = place_entry(slot, r);
            end
        end
        else if (r.req_type == tlfrq_pkg::REQ_PICK)
        begin
            for (int l = 0; l < 3 && !res.next_valid; l++)
            begin
                best = -1;
                for (int i = 0; i < NSLOT; i++)
                    if (sh_valid[i] && sh_lvl[i] == l[1:0] &&
                        (best < 0 || ahead_of(l[1:0], i, best))) best = i;
                if (best >= 0)
                begin
                    sh_valid[best] = 1'b0;
                    res.next_valid = 1'b1;
                    res.next_id = sh_id[best];
                    res.next_level = l[1:0];
                end
            end
        end
        else if (r.req_type == tlfrq_pkg::REQ_TICK)
        begin
            for (int i = 0; i < NSLOT; i++)
            begin
                due[i] = 2'd0;
                if (sh_valid[i])
                begin
                    w = int'(sh_wait[i]) + int'(r_winc);
                    if (w > int'(r_wlim))
                    begin
                        p = int'(sh_prio[i]) + int'(r_boost);
                        if (sh_lvl[i] == tlfrq_pkg::LVL_SRT)
                        begin
                            if (p > int'(r_ceil)) p = int'(r_ceil);
                        end
                        else
                        begin
                            if (p > 255) p = 255;
                            due[i] = sh_lvl[i];
                        end
                        sh_prio[i] = p[7:0];
                        w = w - int'(r_wlim);
                    end
                    sh_wait[i] = w[9:0];
                end
            end
            // Re-place level two entries first, then level three, in queue order.
            for (int s = 1; s <= 2; s++)
            begin
                forever
                begin
                    best = -1;
                    for (int i = 0; i < NSLOT; i++)
                        if (due[i] == s[1:0] && (best < 0 || ahead_of(s[1:0], i, best)))
                            best = i;
                    if (best < 0) break;
                    due[best] = 2'd0;
                    if (place_entry(best, r)) res.preempt = 1'b1;
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] exp_val);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, exp_val);
        mismatches++;
    endtask

    // Driver: hold start until the transfer is taken, then wait a random gap.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req <= '0;
            gap_left <= 0;
        end
        else if (start && !busy_at_edge)
        begin
            // taken at the last rising edge
            start <= 1'b0;
            gap_left <= int'($urandom_range(0, 10));
        end
        else if (!start && pending_reqs.size() > 0 && !hold_off)
        begin
            if (gap_left > 0) gap_left <= gap_left - 1;
            else
            begin
                req <= pending_reqs[0];
                start <= 1'b1;
            end
        end
    end

    // Monitor: predict on each accepted transfer, check each strobed result.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_at_edge <= 1'b1;
        end
        else
        begin
            busy_at_edge <= busy;
            if (start && !busy)
            begin
                expected_results.push_back(schedule_step(req));
                void'(pending_reqs.pop_front());
            end
            if (result_valid)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", 8'd1, 8'd0);
                else
                begin
                    want = expected_results.pop_front();
                    if (result.next_valid !== want.next_valid)
                        report_mismatch("next_valid", 8'(result.next_valid),
                                        8'(want.next_valid));
                    if (result.next_id !== want.next_id)
                        report_mismatch("next_id", result.next_id, want.next_id);
                    if (result.next_level !== want.next_level)
                        report_mismatch("next_level", 8'(result.next_level),
                                        8'(want.next_level));
                    if (result.preempt !== want.preempt)
                        report_mismatch("preempt", 8'(result.preempt), 8'(want.preempt));
                    if (result.insert_dropped !== want.insert_dropped)
                        report_mismatch("insert_dropped", 8'(result.insert_dropped),
                                        8'(want.insert_dropped));
                end
            end
        end
    end

    function automatic tlfrq_pkg::req_t make_req(logic [1:0] kind);
        tlfrq_pkg::req_t r;
        r.req_type = kind;
        r.thread_id = 8'($urandom_range(0, 255));
        r.thread_priority = 8'($urandom_range(0, 255));
        r.thread_remaining = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                         : 16'($urandom_range(0, 40));
        r.running_id = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        r.running_priority = 8'($urandom_range(0, 255));
        r.running_remaining = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                          : 16'($urandom_range(0, 40));
        return r;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [8:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            tlfrq_pkg::CFG_UPPER_FLOOR:  r_upper = val[7:0];
            tlfrq_pkg::CFG_MIDDLE_FLOOR: r_middle = val[7:0];
            tlfrq_pkg::CFG_WAIT_INC:     r_winc = val[7:0];
            tlfrq_pkg::CFG_WAIT_LIMIT:   r_wlim = val;
            tlfrq_pkg::CFG_PRIO_BOOST:   r_boost = val[4:0];
            tlfrq_pkg::CFG_PRIO_CEIL:    r_ceil = val[7:0];
            default: ;
        endcase
    endtask

    // Let the block drain before touching registers.
    task automatic drain();
        wait (pending_reqs.size() == 0 && expected_results.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic queue_phase(int n);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 9);
            // favor inserts so the table fills and aging finds work
            pending_reqs.push_back(make_req(k < 5 ? tlfrq_pkg::REQ_INSERT :
                                            (k < 8 ? tlfrq_pkg::REQ_PICK :
                                                     tlfrq_pkg::REQ_TICK)));
        end
    endtask

    initial
    begin
        hold_off = 1'b1;
        mismatches = 0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int i = 0; i < NSLOT; i++)
        begin
            sh_valid[i] = 1'b0;
            sh_id[i] = '0;
            sh_prio[i] = '0;
            sh_rem[i] = '0;
            sh_wait[i] = '0;
            sh_lvl[i] = '0;
            sh_arr[i] = '0;
        end
        sh_arr_ctr = '0;
        r_upper = tlfrq_pkg::UPPER_FLOOR_RST;
        r_middle = tlfrq_pkg::MIDDLE_FLOOR_RST;
        r_winc = tlfrq_pkg::WAIT_INC_RST;
        r_wlim = tlfrq_pkg::WAIT_LIMIT_RST;
        r_boost = tlfrq_pkg::PRIO_BOOST_RST;
        r_ceil = tlfrq_pkg::PRIO_CEIL_RST;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty pick, extremes of fields, ties, preempt, full table.
        pending_reqs.push_back('{tlfrq_pkg::REQ_PICK, 8'd0, 8'd0, 16'd0,
                                 8'd0, 8'd0, 16'd0});
        pending_reqs.push_back('{tlfrq_pkg::REQ_INSERT, 8'd255, 8'd255, 16'd65535,
                                 8'd1, 8'd0, 16'd65535});
        pending_reqs.push_back('{tlfrq_pkg::REQ_INSERT, 8'd0, 8'd100, 16'd0,
                                 8'd255, 8'd255, 16'd1});
        pending_reqs.push_back('{tlfrq_pkg::REQ_INSERT, 8'd7, 8'd100, 16'd0,
                                 8'd0, 8'd0, 16'd65535});
        pending_reqs.push_back('{tlfrq_pkg::REQ_INSERT, 8'd3, 8'd99, 16'd5,
                                 8'd9, 8'd0, 16'd0});
        pending_reqs.push_back('{tlfrq_pkg::REQ_INSERT, 8'd3, 8'd50, 16'd5,
                                 8'd9, 8'd0, 16'd0});
        pending_reqs.push_back('{tlfrq_pkg::REQ_INSERT, 8'd4, 8'd49, 16'd5,
                                 8'd9, 8'd0, 16'd0});
        pending_reqs.push_back('{tlfrq_pkg::REQ_INSERT, 8'd5, 8'd0, 16'd5,
                                 8'd9, 8'd0, 16'd0});
        for (int i = 0; i < 5; i++)
            pending_reqs.push_back('{tlfrq_pkg::REQ_TICK, 8'd0, 8'd0, 16'd0,
                                     8'd1, 8'd0, 16'd65535});
        for (int i = 0; i < 3; i++)
            pending_reqs.push_back('{tlfrq_pkg::REQ_PICK, 8'd0, 8'd0, 16'd0,
                                     8'd0, 8'd0, 16'd0});
        pending_reqs.push_back('{2'd3, 8'd1, 8'd1, 16'd1, 8'd1, 8'd1, 16'd1});
        // fill past capacity to hit the dropped insert
        for (int i = 0; i < 31; i++) pending_reqs.push_back(make_req(tlfrq_pkg::REQ_INSERT));
        pending_reqs.push_back(make_req(tlfrq_pkg::REQ_TICK));
        for (int i = 0; i < 33; i++) pending_reqs.push_back(make_req(tlfrq_pkg::REQ_PICK));
        hold_off = 1'b0;
        drain();

        // Random phases under several register settings, extremes included.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin
                    write_reg(tlfrq_pkg::CFG_UPPER_FLOOR, 9'd255);
                    write_reg(tlfrq_pkg::CFG_MIDDLE_FLOOR, 9'd0);
                    write_reg(tlfrq_pkg::CFG_WAIT_INC, 9'd255);
                    write_reg(tlfrq_pkg::CFG_WAIT_LIMIT, 9'd0);
                    write_reg(tlfrq_pkg::CFG_PRIO_BOOST, 9'd31);
                    write_reg(tlfrq_pkg::CFG_PRIO_CEIL, 9'd255);
                end
                1: begin
                    write_reg(tlfrq_pkg::CFG_UPPER_FLOOR, 9'd0);
                    write_reg(tlfrq_pkg::CFG_MIDDLE_FLOOR, 9'd255);
                    write_reg(tlfrq_pkg::CFG_WAIT_INC, 9'd0);
                    write_reg(tlfrq_pkg::CFG_WAIT_LIMIT, 9'd511);
                    write_reg(tlfrq_pkg::CFG_PRIO_BOOST, 9'd0);
                    write_reg(tlfrq_pkg::CFG_PRIO_CEIL, 9'd0);
                end
                2: begin
                    write_reg(tlfrq_pkg::CFG_WAIT_INC, 9'd255);
                    write_reg(tlfrq_pkg::CFG_WAIT_LIMIT, 9'd511);
                    write_reg(tlfrq_pkg::CFG_UPPER_FLOOR, 9'd200);
                    write_reg(tlfrq_pkg::CFG_MIDDLE_FLOOR, 9'd100);
                end
                default: begin
                    write_reg(tlfrq_pkg::CFG_UPPER_FLOOR, 9'($urandom_range(0, 255)));
                    write_reg(tlfrq_pkg::CFG_MIDDLE_FLOOR, 9'($urandom_range(0, 255)));
                    write_reg(tlfrq_pkg::CFG_WAIT_INC, 9'($urandom_range(0, 255)));
                    write_reg(tlfrq_pkg::CFG_WAIT_LIMIT, 9'($urandom_range(0, 511)));
                    write_reg(tlfrq_pkg::CFG_PRIO_BOOST, 9'($urandom_range(0, 31)));
                    write_reg(tlfrq_pkg::CFG_PRIO_CEIL, 9'($urandom_range(0, 255)));
                end
            endcase
            queue_phase(200);
            drain();
        end

        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Worst item: tick with 32 re-placements; the timeout also covers the gaps.
    initial
    begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
